// ----- rtl/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg: shared constants for the counter-diabatic amplitude pipeline
// Coefficient integers (scaled by 10^6), the default tilt, quotient and output
// widths, saturation codes and pipeline latencies.
// ----------------------------------------------------------------------------
package cda_pkg;

    // width of every coefficient operand
    localparam int KW = 22;

    localparam logic [KW-1:0] MILLION   = KW'(1000000);
    localparam logic [KW-1:0] K_ONE     = KW'(2108562);
    localparam logic [KW-1:0] K_YZ      = KW'(173984);
    localparam logic [KW-1:0] K_YZ_DEN  = KW'(1468095);
    localparam logic [KW-1:0] K_XY      = KW'(607645);
    localparam logic [KW-1:0] K_ZYZ     = KW'(3054843);
    localparam logic [KW-1:0] K_ZYZ_DEN = KW'(312792);

    // nearest Q4.20 value to 0.35
    localparam int             TILT_W       = 19;
    localparam logic [TILT_W-1:0] TILT_DEFAULT = TILT_W'(367002);

    // multiplier operand chunk
    localparam int CHUNK = 32;

    // quotient magnitude bits and output word
    localparam int QW    = 31;
    localparam int OUT_W = 32;
    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = QW + 1;

endpackage

// ----- rtl/counterdiabatic_amplitudes.sv -----
// Throughput: one request per cycle unless the result stalls; set by the
//   chunked multipliers and the 31-bit restoring dividers, one quotient bit
//   per pipeline stage.
// A stalled result freezes the pipeline; an empty first stage still loads.
// Reset (aresetn low, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
// counterdiabatic_amplitudes: counter-diabatic drive amplitude pipeline
// Forms gap = 4(g^2+J^2)+eps and the four saturated Q8.24 amplitudes by
// pipelined multiplies and four pipelined dividers.
// ----------------------------------------------------------------------------
module counterdiabatic_amplitudes
    import cda_pkg::*;
#(
    parameter int IN_WIDTH = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [IN_WIDTH-1:0] s_transverse_field,
    input  logic signed [IN_WIDTH-1:0] s_field_rate,
    input  logic signed [IN_WIDTH-1:0] s_exchange,
    input  logic signed [IN_WIDTH-1:0] s_tilt,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_W-1:0]    m_one_body_y,
    output logic signed [OUT_W-1:0]    m_two_body_yz,
    output logic signed [OUT_W-1:0]    m_two_body_xy,
    output logic signed [OUT_W-1:0]    m_three_body_zyz
);

    localparam int W    = IN_WIDTH;
    // squares drop bits for wide inputs so they stay within 52 bits
    localparam int SQS  = (2 * W > 52) ? (2 * W - 52) : 0;
    localparam int SQF  = 40 - SQS;
    localparam int SQW  = 2 * W - SQS;
    localparam int GAPW = SQW + 3;
    localparam int HMW  = (W > TILT_W) ? W : TILT_W;
    localparam int DGW  = GAPW + KW;
    localparam int DYW  = DGW + 1;
    localparam int DZW  = 2 * GAPW + KW + 1;
    localparam int N0W  = KW + W;
    localparam int N1W  = KW + 2 * W;
    localparam int N2W  = KW + HMW + W;
    localparam int N3W  = SQW + KW + W;
    localparam logic [63:0] EPS =
        ((64'd1 << SQF) + 64'd50000000) / 64'd100000000;

    // unpack, gap, denominator sum and output stages, multiplies and divider
    localparam int LAT = 1 + MUL_LAT + 1 + MUL_LAT + MUL_LAT + 1 + DIV_LAT + 1;

    // sign bit positions per output
    localparam int SG_ONE = 0;
    localparam int SG_YZ  = 1;
    localparam int SG_XY  = 2;
    localparam int SG_ZYZ = 3;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic en;
    logic vld_reg [LAT];

    // advance everything unless a finished result is held
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en || !vld_reg[0];
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (s_ready) begin
                vld_reg[0] <= s_valid;
            end
            if (en) begin
                for (int k = 1; k < LAT; k++) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---- stage 1: magnitudes, signs, tilt default --------------------------
    logic [W-1:0]   gm_next, dm_next, jm_next, hraw_next;
    logic [HMW-1:0] hm_next;
    logic [3:0]     sgn_next;
    logic [W-1:0]   gm_reg, dm_reg, jm_reg;
    logic [HMW-1:0] hm_reg;
    logic [3:0]     sgn_reg;

    always_comb begin
        gm_next   = mag_of(s_transverse_field);
        dm_next   = mag_of(s_field_rate);
        jm_next   = mag_of(s_exchange);
        hraw_next = mag_of(s_tilt);
        // substitute 0.35 for an exactly zero tilt; its sign is then positive
        hm_next   = (hraw_next == '0) ? HMW'(TILT_DEFAULT) : HMW'(hraw_next);
        sgn_next[SG_ONE] = s_field_rate[W-1];
        sgn_next[SG_YZ]  = s_exchange[W-1] ^ s_field_rate[W-1];
        sgn_next[SG_XY]  = s_tilt[W-1] ^ s_field_rate[W-1];
        sgn_next[SG_ZYZ] = !s_field_rate[W-1];
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            gm_reg  <= gm_next;
            dm_reg  <= dm_next;
            jm_reg  <= jm_next;
            hm_reg  <= hm_next;
            sgn_reg <= sgn_next;
        end
    end

    // ---- first multiply: squares and coefficient products ------------------
    logic [2*W-1:0]    gg, jj;
    logic [N0W-1:0]    k1_dm, kz_dm, kyz_jm;
    logic [KW+HMW-1:0] kxy_hm;

    cda_mul #(.AW(W), .BW(W)) u_mul_gg (
        .aclk(aclk), .en(en), .a(gm_reg), .b(gm_reg), .p(gg));
    cda_mul #(.AW(W), .BW(W)) u_mul_jj (
        .aclk(aclk), .en(en), .a(jm_reg), .b(jm_reg), .p(jj));
    cda_mul #(.AW(W), .BW(KW)) u_mul_k1 (
        .aclk(aclk), .en(en), .a(dm_reg), .b(K_ONE), .p(k1_dm));
    cda_mul #(.AW(W), .BW(KW)) u_mul_kz (
        .aclk(aclk), .en(en), .a(dm_reg), .b(K_ZYZ), .p(kz_dm));
    cda_mul #(.AW(W), .BW(KW)) u_mul_kyz (
        .aclk(aclk), .en(en), .a(jm_reg), .b(K_YZ), .p(kyz_jm));
    cda_mul #(.AW(HMW), .BW(KW)) u_mul_kxy (
        .aclk(aclk), .en(en), .a(hm_reg), .b(K_XY), .p(kxy_hm));

    logic [W-1:0] dm_d;

    cda_delay #(.W(W), .DEPTH(MUL_LAT + 1)) u_dly_dm (
        .aclk(aclk), .en(en), .d(dm_reg), .q(dm_d));

    // ---- gap stage ---------------------------------------------------------
    logic [SQW-1:0]    g2_next, j2_next;
    logic [GAPW-1:0]   sum_next, gap_next;
    logic [SQW-1:0]    j2_reg;
    logic [GAPW-1:0]   gap_reg;
    logic [N0W-1:0]    n0_reg, kz_reg, kyz_reg;
    logic [KW+HMW-1:0] kxy_reg;

    always_comb begin
        g2_next  = gg[2*W-1:SQS];
        j2_next  = jj[2*W-1:SQS];
        sum_next = GAPW'(g2_next) + GAPW'(j2_next);
        gap_next = (sum_next << 2) + GAPW'(EPS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j2_reg  <= j2_next;
            gap_reg <= gap_next;
            n0_reg  <= k1_dm;
            kz_reg  <= kz_dm;
            kyz_reg <= kyz_jm;
            kxy_reg <= kxy_hm;
        end
    end

    // ---- second multiply: scaled gap, J^2 terms, numerators ----------------
    logic [DGW-1:0]    den_gap, j2k, j2z;
    logic [N1W-1:0]    n1;
    logic [N2W-1:0]    n2;
    logic [N3W-1:0]    n3;

    cda_mul #(.AW(GAPW), .BW(KW)) u_mul_dg (
        .aclk(aclk), .en(en), .a(gap_reg), .b(MILLION), .p(den_gap));
    cda_mul #(.AW(SQW), .BW(KW)) u_mul_jk (
        .aclk(aclk), .en(en), .a(j2_reg), .b(K_YZ_DEN), .p(j2k[SQW+KW-1:0]));
    cda_mul #(.AW(SQW), .BW(KW)) u_mul_jz (
        .aclk(aclk), .en(en), .a(j2_reg), .b(K_ZYZ_DEN), .p(j2z[SQW+KW-1:0]));
    cda_mul #(.AW(N0W), .BW(W)) u_mul_n1 (
        .aclk(aclk), .en(en), .a(kyz_reg), .b(dm_d), .p(n1));
    cda_mul #(.AW(KW+HMW), .BW(W)) u_mul_n2 (
        .aclk(aclk), .en(en), .a(kxy_reg), .b(dm_d), .p(n2));
    cda_mul #(.AW(SQW), .BW(N0W)) u_mul_n3 (
        .aclk(aclk), .en(en), .a(j2_reg), .b(kz_reg), .p(n3));

    // squares are three bits narrower than the gap
    assign j2k[DGW-1:SQW+KW] = '0;
    assign j2z[DGW-1:SQW+KW] = '0;

    logic [GAPW-1:0] gap_d;
    logic [SQW-1:0]  j2_d;

    cda_delay #(.W(GAPW), .DEPTH(MUL_LAT)) u_dly_gap (
        .aclk(aclk), .en(en), .d(gap_reg), .q(gap_d));
    cda_delay #(.W(SQW), .DEPTH(MUL_LAT)) u_dly_j2 (
        .aclk(aclk), .en(en), .d(j2_reg), .q(j2_d));

    // ---- third multiply: gap^2 and J^4 terms -------------------------------
    logic [GAPW+DGW-1:0] gap_sq;
    logic [SQW+DGW-1:0]  j4k;

    cda_mul #(.AW(GAPW), .BW(DGW)) u_mul_gsq (
        .aclk(aclk), .en(en), .a(gap_d), .b(den_gap), .p(gap_sq));
    cda_mul #(.AW(SQW), .BW(DGW)) u_mul_j4 (
        .aclk(aclk), .en(en), .a(j2_d), .b(j2z), .p(j4k));

    logic [DGW-1:0] den_gap_d, j2k_d;

    cda_delay #(.W(DGW), .DEPTH(MUL_LAT)) u_dly_dg (
        .aclk(aclk), .en(en), .d(den_gap), .q(den_gap_d));
    cda_delay #(.W(DGW), .DEPTH(MUL_LAT)) u_dly_jk (
        .aclk(aclk), .en(en), .d(j2k), .q(j2k_d));

    // ---- denominator stage -------------------------------------------------
    logic [DGW-1:0] den_gap_reg;
    logic [DYW-1:0] den_yz_reg;
    logic [DZW-1:0] den_zyz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_gap_reg <= den_gap_d;
            den_yz_reg  <= DYW'(den_gap_d) + DYW'(j2k_d);
            den_zyz_reg <= DZW'(gap_sq) + DZW'(j4k);
        end
    end

    // align numerators and signs with the denominators
    logic [N0W-1:0] n0_d;
    logic [N1W-1:0] n1_d;
    logic [N2W-1:0] n2_d;
    logic [N3W-1:0] n3_d;
    logic [3:0]     sgn_d;

    cda_delay #(.W(N0W), .DEPTH(2 * MUL_LAT + 1)) u_dly_n0 (
        .aclk(aclk), .en(en), .d(n0_reg), .q(n0_d));
    cda_delay #(.W(N1W), .DEPTH(MUL_LAT + 1)) u_dly_n1 (
        .aclk(aclk), .en(en), .d(n1), .q(n1_d));
    cda_delay #(.W(N2W), .DEPTH(MUL_LAT + 1)) u_dly_n2 (
        .aclk(aclk), .en(en), .d(n2), .q(n2_d));
    cda_delay #(.W(N3W), .DEPTH(MUL_LAT + 1)) u_dly_n3 (
        .aclk(aclk), .en(en), .d(n3), .q(n3_d));
    cda_delay #(.W(4), .DEPTH(3 * MUL_LAT + 2)) u_dly_sgn (
        .aclk(aclk), .en(en), .d(sgn_reg), .q(sgn_d));

    // ---- dividers ----------------------------------------------------------
    logic [OUT_W-1:0] one_res, yz_res, xy_res, zyz_res;

    cda_div #(.NW(N0W), .SH(SQF + 4), .DW(DGW)) u_div_one (
        .aclk(aclk), .en(en), .num(n0_d), .den(den_gap_reg),
        .neg(sgn_d[SG_ONE]), .res(one_res));
    cda_div #(.NW(N1W), .SH(SQF - 16), .DW(DYW)) u_div_yz (
        .aclk(aclk), .en(en), .num(n1_d), .den(den_yz_reg),
        .neg(sgn_d[SG_YZ]), .res(yz_res));
    cda_div #(.NW(N2W), .SH(SQF - 16), .DW(DGW)) u_div_xy (
        .aclk(aclk), .en(en), .num(n2_d), .den(den_gap_reg),
        .neg(sgn_d[SG_XY]), .res(xy_res));
    cda_div #(.NW(N3W), .SH(SQF + 4), .DW(DZW)) u_div_zyz (
        .aclk(aclk), .en(en), .num(n3_d), .den(den_zyz_reg),
        .neg(sgn_d[SG_ZYZ]), .res(zyz_res));

    // ---- output register: hold while the result request waits -------------
    logic [OUT_W-1:0] one_reg, yz_reg, xy_reg, zyz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            one_reg <= one_res;
            yz_reg  <= yz_res;
            xy_reg  <= xy_res;
            zyz_reg <= zyz_res;
        end
    end

    assign m_one_body_y     = $signed(one_reg);
    assign m_two_body_yz    = $signed(yz_reg);
    assign m_two_body_xy    = $signed(xy_reg);
    assign m_three_body_zyz = $signed(zyz_reg);

endmodule

// ----- rtl/cda_delay.sv -----
// ----------------------------------------------------------------------------
// cda_delay: stall-aware delay line
// Shifts a payload through DEPTH en-gated registers to align it with the datapath.
// ----------------------------------------------------------------------------
module cda_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// ----- rtl/cda_mul.sv -----
// ----------------------------------------------------------------------------
// cda_mul: two-stage unsigned multiplier
// Splits both operands into 32-bit chunks, registers the partial products,
// then sums them into the registered full-width product.
// ----------------------------------------------------------------------------
module cda_mul
    import cda_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int NA = (AW + CHUNK - 1) / CHUNK;
    localparam int NB = (BW + CHUNK - 1) / CHUNK;
    localparam int PW = AW + BW;
    localparam int SW = (NA + NB) * CHUNK;

    logic [NA*CHUNK-1:0] a_ext;
    logic [NB*CHUNK-1:0] b_ext;
    logic [2*CHUNK-1:0]  pp_reg [NA*NB];
    logic [SW-1:0]       sum_next;
    logic [PW-1:0]       p_reg;

    assign a_ext = (NA*CHUNK)'(a);
    assign b_ext = (NB*CHUNK)'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i*NB+j] <= a_ext[i*CHUNK +: CHUNK] * b_ext[j*CHUNK +: CHUNK];
                end
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum_next = sum_next + (SW'(pp_reg[i*NB+j]) << (CHUNK * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum_next[PW-1:0];
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/cda_div.sv -----
// ----------------------------------------------------------------------------
// cda_div: pipelined saturating restoring divider
// Gives floor(num * 2^SH / den), negated if neg, as signed Q8.24 with
// saturation: one stage checks for overflow, then one stage per quotient bit.
// ----------------------------------------------------------------------------
module cda_div
    import cda_pkg::*;
#(
    parameter int NW = 40,
    parameter int SH = 20,
    parameter int DW = 64
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    input  logic             neg,
    output logic [OUT_W-1:0] res
);

    localparam int XW  = NW + SH;
    localparam int XHW = XW - QW;
    localparam int CW  = (XHW > DW) ? XHW : DW;
    localparam int LST = DIV_LAT - 1;

    logic [XW-1:0]  x;
    logic [XHW-1:0] x_hi;
    logic           sat_next;

    logic [DW-1:0] rem_reg [DIV_LAT];
    logic [QW-1:0] q_reg   [DIV_LAT];
    logic [QW-1:0] xlo_reg [DIV_LAT];
    logic [DW-1:0] den_reg [DIV_LAT];
    logic          neg_reg [DIV_LAT];
    logic          sat_reg [DIV_LAT];

    logic [DW:0]   trial  [DIV_LAT];
    logic          fits   [DIV_LAT];
    logic [DW-1:0] rem_next [DIV_LAT];

    assign x        = {num, {SH{1'b0}}};
    assign x_hi     = x[XW-1:QW];
    // quotient reaches 2^31 exactly when the high part is not below den
    assign sat_next = CW'(x_hi) >= CW'(den);

    always_comb begin
        trial[0]    = '0;
        fits[0]     = 1'b0;
        rem_next[0] = '0;
        for (int k = 1; k < DIV_LAT; k++) begin
            trial[k]    = {rem_reg[k-1], xlo_reg[k-1][QW-1]};
            fits[k]     = trial[k] >= {1'b0, den_reg[k-1]};
            rem_next[k] = fits[k] ? DW'(trial[k] - {1'b0, den_reg[k-1]}) : DW'(trial[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(x_hi);
            q_reg[0]   <= '0;
            xlo_reg[0] <= x[QW-1:0];
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            sat_reg[0] <= sat_next;
            for (int k = 1; k < DIV_LAT; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], fits[k]};
                xlo_reg[k] <= xlo_reg[k-1] << 1;
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    always_comb begin
        if (sat_reg[LST]) begin
            res = neg_reg[LST] ? SAT_NEG : SAT_POS;
        end else if (neg_reg[LST]) begin
            res = OUT_W'(0) - {1'b0, q_reg[LST]};
        end else begin
            res = {1'b0, q_reg[LST]};
        end
    end

endmodule
